// ===== hdl/bj0i0_pkg.sv =====
// shared types, widths and coefficient table for the bessel j0/i0 series block
// no dependencies; used by every module under hdl
package bj0i0_pkg;

   // default and largest supported last power of the series
   localparam int MAX_POWER_DEF = 8;
   localparam int MAX_POWER_TOP = 12;

   // selector codes on the op field
   localparam logic OP_J0 = 1'b0;
   localparam logic OP_I0 = 1'b1;

   // argument, squared argument, accumulator magnitude and coefficient widths
   localparam int ARG_W   = 16;
   localparam int XMAG_W  = 31;
   localparam int SMAG_W  = 63;
   localparam int COEF_W  = 47;
   localparam int VALUE_W = 32;

   // accumulator magnitude limit, 2^62 at scale 2^-46
   localparam logic [SMAG_W-1:0] ACC_CAP = {1'b1, {(SMAG_W-1){1'b0}}};

   typedef logic [COEF_W-1:0] coef_type;

   // 1/(k!)^2 at scale 2^-46, rounded half up, k = 0 .. 12
   localparam coef_type COEF_TABLE [0:MAX_POWER_TOP] = '{
      47'd70368744177664,
      47'd70368744177664,
      47'd17592186044416,
      47'd1954687338268,
      47'd122167958642,
      47'd4886718346,
      47'd135742176,
      47'd2770248,
      47'd43285,
      47'd534,
      47'd5,
      47'd0,
      47'd0
   };

   // partial sum handed from cell to cell, kept as sign and magnitude
   typedef struct packed {
      logic              valid;
      logic              xneg;
      logic [XMAG_W-1:0] xmag;
      logic              sneg;
      logic [SMAG_W-1:0] smag;
      logic              clip;
   } acc_type;

   // finished result item
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      saturated;
   } res_type;

endpackage

// ===== hdl/bj0i0_square.sv =====
// front stage: forms x = z*z/4 magnitude and sign, seeds the sum with the top coefficient
// depends on bj0i0_pkg
module bj0i0_square #(
   parameter int MAX_POWER = bj0i0_pkg::MAX_POWER_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [bj0i0_pkg::ARG_W-1:0]   arg_z,
   input  logic                                 op,
   output bj0i0_pkg::acc_type                   acc_o
);

   localparam bj0i0_pkg::coef_type SEED = bj0i0_pkg::COEF_TABLE[MAX_POWER];

   logic [bj0i0_pkg::ARG_W-1:0]   zmag;
   logic [2*bj0i0_pkg::ARG_W-1:0] zsq;
   bj0i0_pkg::acc_type            acc_in;
   bj0i0_pkg::acc_type            acc_ff;

   // magnitude of -32768 still fits unsigned 16 bits
   assign zmag = arg_z[bj0i0_pkg::ARG_W-1] ? (~arg_z) + 1'b1 : arg_z;
   assign zsq  = zmag * zmag;

   always_comb begin
      acc_in.valid = in_valid;
      acc_in.xneg  = (op == bj0i0_pkg::OP_J0);
      acc_in.xmag  = zsq[bj0i0_pkg::XMAG_W-1:0];
      acc_in.sneg  = 1'b0;
      acc_in.smag  = bj0i0_pkg::SMAG_W'(SEED);
      acc_in.clip  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.valid <= 1'b0;
      end else if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_o = acc_ff;

endmodule

// ===== hdl/bj0i0_cell.sv =====
// one horner cell: s = c_k + round(s * x / 2^26), three register stages
// depends on bj0i0_pkg
module bj0i0_cell #(
   parameter int COEF_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  bj0i0_pkg::acc_type acc_i,
   output bj0i0_pkg::acc_type acc_o
);

   localparam int XW = bj0i0_pkg::XMAG_W;
   localparam int SW = bj0i0_pkg::SMAG_W;
   localparam int HI_W = SW - 32;
   localparam int QHI_W = HI_W + XW;
   localparam int PLO_W = 32 + XW;
   localparam logic [SW-1:0] COEF = SW'(bj0i0_pkg::COEF_TABLE[COEF_IDX]);
   localparam logic [63:0] LO_HALF = 64'd1 << 25;

   // stage a: split product
   logic             a_valid_ff;
   logic             a_xneg_ff, a_sneg_ff, a_clip_ff;
   logic [XW-1:0]    a_xmag_ff;
   logic [QHI_W-1:0] a_qhi_ff, a_qhi_in;
   logic [PLO_W-1:0] a_plo_ff, a_plo_in;

   assign a_qhi_in = acc_i.smag[SW-1:32] * acc_i.xmag;
   assign a_plo_in = acc_i.smag[31:0] * acc_i.xmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= acc_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_xneg_ff <= acc_i.xneg;
         a_xmag_ff <= acc_i.xmag;
         a_sneg_ff <= acc_i.sneg;
         a_clip_ff <= acc_i.clip;
         a_qhi_ff  <= a_qhi_in;
         a_plo_ff  <= a_plo_in;
      end
   end

   // stage b: combine partial products, round, clip the product
   logic          b_valid_ff;
   logic          b_xneg_ff, b_pneg_ff, b_clip_ff;
   logic [XW-1:0] b_xmag_ff;
   logic [SW-1:0] b_pmag_ff, b_pmag_in;
   logic [63:0]   lo_rnd, mag_sum;
   logic          hi_ovf, p_over;

   assign lo_rnd  = 64'(a_plo_ff) + LO_HALF;
   assign mag_sum = {2'b00, a_qhi_ff[55:0], 6'b000000} + 64'(lo_rnd[63:26]);
   assign hi_ovf  = |a_qhi_ff[QHI_W-1:56];
   assign p_over  = hi_ovf || (mag_sum > 64'(bj0i0_pkg::ACC_CAP));
   assign b_pmag_in = p_over ? bj0i0_pkg::ACC_CAP : mag_sum[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_xneg_ff <= a_xneg_ff;
         b_xmag_ff <= a_xmag_ff;
         b_pneg_ff <= a_sneg_ff ^ a_xneg_ff;
         b_clip_ff <= a_clip_ff | p_over;
         b_pmag_ff <= b_pmag_in;
      end
   end

   // stage c: add the coefficient in sign-magnitude form, clip the sum
   logic [63:0]        sum_pos, mag64;
   logic [SW-1:0]      diff_pc, diff_cp;
   logic               p_gt, t_neg, t_over;
   bj0i0_pkg::acc_type acc_in, acc_ff;

   assign sum_pos = 64'(b_pmag_ff) + 64'(COEF);
   assign diff_pc = b_pmag_ff - COEF;
   assign diff_cp = COEF - b_pmag_ff;
   assign p_gt    = b_pmag_ff > COEF;

   always_comb begin
      if (!b_pneg_ff) begin
         t_neg = 1'b0;
         mag64 = sum_pos;
      end else if (p_gt) begin
         t_neg = 1'b1;
         mag64 = 64'(diff_pc);
      end else begin
         t_neg = 1'b0;
         mag64 = 64'(diff_cp);
      end
   end

   assign t_over = mag64 > 64'(bj0i0_pkg::ACC_CAP);

   always_comb begin
      acc_in.valid = b_valid_ff;
      acc_in.xneg  = b_xneg_ff;
      acc_in.xmag  = b_xmag_ff;
      acc_in.sneg  = t_neg;
      acc_in.smag  = t_over ? bj0i0_pkg::ACC_CAP : mag64[SW-1:0];
      acc_in.clip  = b_clip_ff | t_over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.valid <= 1'b0;
      end else if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_o = acc_ff;

endmodule

// ===== hdl/bj0i0_round.sv =====
// output conversion: scale 2^-46 sum to q15.16, round half away from zero, saturate
// depends on bj0i0_pkg
module bj0i0_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  bj0i0_pkg::acc_type acc_i,
   output bj0i0_pkg::res_type res_o
);

   localparam int VW = bj0i0_pkg::VALUE_W;
   localparam int RW = VW + 2;
   localparam logic [63:0]   RND_HALF = 64'd1 << 29;
   localparam logic [RW-1:0] POS_MAX  = RW'({1'b0, {(VW-1){1'b1}}});
   localparam logic [RW-1:0] NEG_MAX  = RW'({1'b1, {(VW-1){1'b0}}});

   logic [63:0]        rnd;
   logic [RW-1:0]      r;
   logic               sat;
   logic [VW-1:0]      r_sel;
   bj0i0_pkg::res_type res_in, res_ff;

   assign rnd = 64'(acc_i.smag) + RND_HALF;
   assign r   = rnd[RW+29:30];
   assign sat = acc_i.clip
             || (!acc_i.sneg && (r > POS_MAX))
             || (acc_i.sneg && (r > NEG_MAX));

   always_comb begin
      if (sat) begin
         r_sel = acc_i.sneg ? NEG_MAX[VW-1:0] : POS_MAX[VW-1:0];
      end else begin
         r_sel = r[VW-1:0];
      end
   end

   always_comb begin
      res_in.valid     = acc_i.valid;
      res_in.value     = acc_i.sneg ? (~r_sel) + 1'b1 : r_sel;
      res_in.saturated = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_o = res_ff;

endmodule

// ===== hdl/bessel_j0_i0_series.sv =====
// top level of the bessel j0/i0 power series block: square stage, horner cell chain,
// output conversion, output register with skid; depends on bj0i0_pkg and the hdl modules
//
// usage:
//   req channel: req_arg_z (signed q3.12) and req_op (0 = j0, 1 = i0), valid/ready
//   rsp channel: rsp_value (signed q15.16) and rsp_saturated, valid/ready
//   one result item for every accepted item, in order
// timing:
//   a new item is taken every cycle while the output side keeps up; an accepted item
//   passes the square stage, the chain of MAX_POWER horner cells, each with a product stage,
//   a rounding stage and a coefficient add stage, then the conversion stage and the
//   output register before rsp_valid
// stall:
//   the output register and a one-item skid part the two sides; when the skid holds
//   an item the whole chain holds and req_ready is low until the skid drains
// reset:
//   synchronous, active high; all valid bits clear, so nothing is in flight afterwards
module bessel_j0_i0_series #(
   parameter int MAX_POWER = bj0i0_pkg::MAX_POWER_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [bj0i0_pkg::ARG_W-1:0]    req_arg_z,
   input  logic                                  req_op,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bj0i0_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                  rsp_saturated
);

   // chain advance; the whole pipeline moves together while the skid is free
   logic en;

   // partial sums between cells; entry 0 is the seeded sum from the square stage
   bj0i0_pkg::acc_type chain [0:MAX_POWER];
   bj0i0_pkg::res_type pipe_res;

   // output register and skid
   logic                              out_valid_ff, out_valid_in;
   logic                              skid_valid_ff, skid_valid_in;
   logic [bj0i0_pkg::VALUE_W-1:0]     out_value_ff, out_value_in;
   logic                              out_sat_ff, out_sat_in;
   logic [bj0i0_pkg::VALUE_W-1:0]     skid_value_ff, skid_value_in;
   logic                              skid_sat_ff, skid_sat_in;
   logic                              take, drain;

   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   // x = z*z/4 with sign from the selector, sum seeded with the top coefficient
   bj0i0_square #(
      .MAX_POWER (MAX_POWER)
   ) u_square (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid & req_ready),
      .arg_z    (req_arg_z),
      .op       (req_op),
      .acc_o    (chain[0])
   );

   // horner cells, highest remaining power first
   for (genvar i = 0; i < MAX_POWER; i++) begin : g_cell
      bj0i0_cell #(
         .COEF_IDX (MAX_POWER - 1 - i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .acc_i (chain[i]),
         .acc_o (chain[i+1])
      );
   end

   // scale, round and saturate to q15.16
   bj0i0_round u_round (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .acc_i (chain[MAX_POWER]),
      .res_o (pipe_res)
   );

   // a finished item leaves the chain only on a cycle the chain advances
   assign take  = en & pipe_res.valid;
   assign drain = out_valid_ff & rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_sat_in    = out_sat_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      skid_sat_in   = skid_sat_ff;
      if (skid_valid_ff) begin
         // chain is held; refill the output register from the skid
         if (drain) begin
            out_value_in  = skid_value_ff;
            out_sat_in    = skid_sat_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || drain) begin
            out_valid_in = 1'b1;
            out_value_in = pipe_res.value;
            out_sat_in   = pipe_res.saturated;
         end else begin
            // receiver stalled; park the item
            skid_valid_in = 1'b1;
            skid_value_in = pipe_res.value;
            skid_sat_in   = pipe_res.saturated;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_sat_ff    <= out_sat_in;
      skid_value_ff <= skid_value_in;
      skid_sat_ff   <= skid_sat_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_saturated = out_sat_ff;

   // skid only ever holds an item behind a held output item
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while the output register is empty");

   // skid fills only after the receiver stalled a waiting item
   a_skid_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid filled without an output stall");

   // a saturated item carries one of the two bounds
   a_sat_is_bound : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sat_ff) |->
         (out_value_ff == {1'b0, {(bj0i0_pkg::VALUE_W-1){1'b1}}})
         || (out_value_ff == {1'b1, {(bj0i0_pkg::VALUE_W-1){1'b0}}}))
      else $error("saturated item is not at an output bound");

   // a held skid item drains into the output register when the receiver takes
   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid item did not move to the output register");

endmodule
